// ===== hdl/lir_pkg.sv =====
// lir_pkg: shared constants, codes and types of the linear interpolation resampler.
// Used by lir_lane, lir_div, lir_merge and linear_interp_resampler.
package lir_pkg;

    localparam int LANES         = 4;
    localparam int SAMPLE_W      = 32;
    localparam int TDATA_W       = LANES * SAMPLE_W;
    localparam int STEP_W        = 24;
    localparam int CHAN_W        = 3;
    localparam int OFR_W         = 31;
    localparam int FRAME_W       = 32;
    localparam int MAX_OUT       = 32;
    localparam int CNT_W         = $clog2(MAX_OUT + 1);
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = OFR_W;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [STEP_W-1:0] STEP_RST = STEP_W'(65536);
    localparam logic [CHAN_W-1:0] CHAN_RST = CHAN_W'(2);
    localparam logic [OFR_W-1:0]  OFR_RST  = OFR_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP = 2'd0,
        CFG_CHAN = 2'd1,
        CFG_OFR  = 2'd2
    } t_cfg_idx;

    typedef logic [LANES-1:0][SAMPLE_W-1:0] t_frame;

    typedef struct packed {
        logic load;     // sample operands, start products
        logic finish;   // sum and truncate
    } t_lane_ctl;

    typedef struct packed {
        logic push;       // new lane result into the hold stage
        logic release_;   // hold stage out as last item of the run
        logic sound_end;
    } t_merge_ctl;

    typedef struct packed {
        logic hold_valid;
        logic out_free;
    } t_merge_sts;

endpackage

// ===== hdl/lir_lane.sv =====
// lir_lane: one channel lane, prev*(1-frac) + cur*frac, truncated toward zero.
// Two register stages: products, then sum. Depends on lir_pkg.
module lir_lane #(
    parameter int FRAC_BITS = lir_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  lir_pkg::t_lane_ctl            i_ctl,
    input  logic [lir_pkg::SAMPLE_W-1:0]  i_prev,
    input  logic [lir_pkg::SAMPLE_W-1:0]  i_cur,
    input  logic [FRAC_BITS-1:0]          i_frac,
    output logic [lir_pkg::SAMPLE_W-1:0]  o_res
);

    localparam int PROD_W = lir_pkg::SAMPLE_W + FRAC_BITS + 1;
    localparam int SUM_W  = PROD_W + 1;

    logic [FRAC_BITS:0]        wp;
    logic signed [PROD_W-1:0]  r_p0;
    logic signed [PROD_W-1:0]  r_p1;
    logic signed [SUM_W-1:0]   sum;
    logic signed [SUM_W-1:0]   shq;
    logic                      rnd;
    logic [SUM_W-1:0]          q;
    logic [lir_pkg::SAMPLE_W-1:0] r_res;

    assign wp = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, i_frac};

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_p0 <= $signed(i_prev) * $signed({1'b0, wp});
            r_p1 <= $signed(i_cur) * $signed({1'b0, i_frac});
        end
    end

    // arithmetic shift floors; add one back for negative values with a fraction
    assign sum = SUM_W'(r_p0) + SUM_W'(r_p1);
    assign shq = sum >>> FRAC_BITS;
    assign rnd = sum[SUM_W-1] && (sum[FRAC_BITS-1:0] != '0);
    assign q   = shq + {{(SUM_W-1){1'b0}}, rnd};

    always_ff @(posedge i_clk) begin
        if (i_ctl.finish) begin
            r_res <= q[lir_pkg::SAMPLE_W-1:0];
        end
    end

    assign o_res = r_res;

endmodule

// ===== hdl/lir_div.sv =====
// lir_div: restoring divider, one quotient bit per cycle.
// Used for the skip over outputs beyond the per-item limit. Depends on lir_pkg.
module lir_div #(
    parameter int DW = 49,
    parameter int VW = lir_pkg::STEP_W
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot
);

    localparam int DCNT_W = $clog2(DW + 1);

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [VW-1:0]     r_rem;
    logic [VW-1:0]     r_dv;
    logic [DW-1:0]     r_q;
    logic [VW:0]       trial;
    logic              fits;

    assign trial = {r_rem, r_q[DW-1]};
    assign fits  = trial >= {1'b0, r_dv};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(DW);
                r_rem  <= '0;
                r_q    <= i_dividend;
                r_dv   <= i_divisor;
            end else if (r_busy) begin
                r_rem <= fits ? VW'(trial - {1'b0, r_dv}) : trial[VW-1:0];
                r_q   <= {r_q[DW-2:0], fits};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== hdl/lir_merge.sv =====
// lir_merge: merges lane results into one output item, holds back the latest
// item until its run flags are known, and drives the master stream. Depends on lir_pkg.
module lir_merge (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lir_pkg::t_merge_ctl          i_ctl,
    input  lir_pkg::t_frame              i_res,
    output lir_pkg::t_merge_sts          o_sts,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [lir_pkg::TDATA_W-1:0]  o_m_tdata,
    output logic                         o_m_tlast,
    output logic                         o_m_tuser
);

    lir_pkg::t_frame             r_hold;
    logic                        r_hv;
    logic [lir_pkg::TDATA_W-1:0] r_data;
    logic                        r_ov;
    logic                        r_last;
    logic                        r_user;
    logic                        out_free;
    logic                        load;

    assign out_free = !r_ov || i_m_tready;
    assign load     = (i_ctl.push && r_hv) || i_ctl.release_;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (i_ctl.push) begin
                r_hv <= 1'b1;
            end else if (i_ctl.release_) begin
                r_hv <= 1'b0;
            end
            if (load) begin
                r_ov <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_hold <= i_res;
        end
        if (load) begin
            r_data <= r_hold;
            r_last <= i_ctl.release_;
            r_user <= i_ctl.release_ && i_ctl.sound_end;
        end
    end

    assign o_sts.hold_valid = r_hv;
    assign o_sts.out_free   = out_free;
    assign o_m_tvalid       = r_ov;
    assign o_m_tdata        = r_data;
    assign o_m_tlast        = r_last;
    assign o_m_tuser        = r_user;

endmodule

// ===== hdl/linear_interp_resampler.sv =====
// linear_interp_resampler: multi-channel linear interpolation rate converter.
// One input item at a time; the lane pipeline takes one result at a time, and the input
// is not ready again until all results of the item are issued and handed on. Each result
// is held back in the merge stage until its run flags are known. When the 32-result limit
// cuts an item short, a divider (one quotient bit a cycle), a multiply and an add skip the
// outputs beyond it. Synchronous active-low reset.
module linear_interp_resampler #(
    parameter int FRAC_BITS = lir_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lir_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lir_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // sample_a [31:0], sample_b [63:32], sample_c [95:64], sample_d [127:96]
    input  logic [lir_pkg::TDATA_W-1:0]    i_s_tdata,
    input  logic                           i_s_tlast,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // result_a [31:0], result_b [63:32], result_c [95:64], result_d [127:96]
    output logic [lir_pkg::TDATA_W-1:0]    o_m_tdata,
    output logic                           o_m_tlast,
    // sound_end [0]
    output logic                           o_m_tuser
);

    localparam int PHASE_W = lir_pkg::FRAME_W + FRAC_BITS + 1;
    localparam int PROD_W  = lir_pkg::OFR_W + lir_pkg::STEP_W;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_INTERP = 7'b0000010,
        S_DIV    = 7'b0000100,
        S_MUL    = 7'b0001000,
        S_ADD    = 7'b0010000,
        S_FLUSH  = 7'b0100000,
        S_DRAIN  = 7'b1000000
    } t_state;

    t_state                         r_state, n_state;
    logic [lir_pkg::STEP_W-1:0]     r_step;
    logic [lir_pkg::CHAN_W-1:0]     r_chan;
    logic [lir_pkg::OFR_W-1:0]      r_ofr;
    lir_pkg::t_frame                r_prev, n_prev;
    lir_pkg::t_frame                r_cur, n_cur;
    logic                           r_fin, n_fin;
    logic                           r_have, n_have;
    logic [lir_pkg::FRAME_W-1:0]    r_frame, n_frame;
    logic [PHASE_W-1:0]             r_phase, n_phase;
    logic [lir_pkg::OFR_W-1:0]      r_emit, n_emit;
    logic [lir_pkg::CNT_W-1:0]      r_n, n_n;
    logic                           r_interp, n_interp;
    logic                           r_reached, n_reached;
    logic                           r_v1;
    logic                           r_rv, n_rv;
    logic [lir_pkg::OFR_W-1:0]      r_skip, n_skip;
    logic [PROD_W-1:0]              r_prod, n_prod;

    logic [lir_pkg::STEP_W-1:0]     step_eff;
    logic [lir_pkg::CHAN_W-1:0]     act;
    logic [PHASE_W-1:0]             hi;
    logic [lir_pkg::OFR_W-1:0]      left;
    logic                           slot_free;
    logic                           emit_lt;
    logic                           more;
    logic                           at_max;
    logic                           issue;
    logic                           div_start;
    logic [PHASE_W-1:0]             dividend;
    logic                           div_done;
    logic [PHASE_W-1:0]             quot;
    lir_pkg::t_lane_ctl             lane_ctl;
    lir_pkg::t_frame                lane_prev;
    logic [FRAC_BITS-1:0]           lane_frac;
    lir_pkg::t_frame                lane_res;
    lir_pkg::t_merge_ctl            mctl;
    lir_pkg::t_merge_sts            msts;

    assign step_eff  = (r_step == '0) ? lir_pkg::STEP_W'(1) : r_step;
    assign act       = (r_chan == '0) ? lir_pkg::CHAN_W'(1) :
                       (r_chan > lir_pkg::CHAN_W'(lir_pkg::LANES)) ?
                       lir_pkg::CHAN_W'(lir_pkg::LANES) : r_chan;
    assign hi        = PHASE_W'({r_frame, {FRAC_BITS{1'b0}}});
    assign left      = r_ofr - r_emit;
    assign slot_free = !r_v1 && !r_rv;
    assign emit_lt   = r_emit < r_ofr;
    assign more      = emit_lt && (r_phase < hi);
    assign at_max    = r_n == lir_pkg::CNT_W'(lir_pkg::MAX_OUT);
    assign dividend  = hi - r_phase + PHASE_W'(step_eff) - PHASE_W'(1);

    assign lane_prev = (r_state == S_FLUSH) ? r_cur : r_prev;
    assign lane_frac = (r_state == S_FLUSH) ? '0 : r_phase[FRAC_BITS-1:0];

    assign o_s_tready = r_state == S_IDLE;

    assign mctl.push      = r_rv && (!msts.hold_valid || msts.out_free);
    assign mctl.release_  = (r_state == S_DRAIN) && slot_free && msts.hold_valid
                            && msts.out_free;
    assign mctl.sound_end = r_reached;

    assign lane_ctl.load   = issue;
    assign lane_ctl.finish = r_v1;

    always_comb begin
        n_state   = r_state;
        n_prev    = r_prev;
        n_cur     = r_cur;
        n_fin     = r_fin;
        n_have    = r_have;
        n_frame   = r_frame;
        n_phase   = r_phase;
        n_emit    = r_emit;
        n_n       = r_n;
        n_interp  = r_interp;
        n_reached = r_reached;
        n_skip    = r_skip;
        n_prod    = r_prod;
        issue     = 1'b0;
        div_start = 1'b0;
        n_rv      = r_v1 ? 1'b1 : (mctl.push ? 1'b0 : r_rv);

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    for (int i = 0; i < lir_pkg::LANES; i++) begin
                        n_cur[i] = (lir_pkg::CHAN_W'(i) < act) ?
                                   i_s_tdata[i*lir_pkg::SAMPLE_W +: lir_pkg::SAMPLE_W] : '0;
                    end
                    n_fin     = i_s_tlast;
                    n_n       = '0;
                    n_reached = 1'b0;
                    n_interp  = r_have && emit_lt;
                    n_state   = S_INTERP;
                end
            end
            S_INTERP: begin
                if (slot_free) begin
                    if (r_interp && more) begin
                        if (at_max) begin
                            div_start = 1'b1;
                            n_state   = S_DIV;
                        end else begin
                            issue   = 1'b1;
                            n_n     = r_n + 1'b1;
                            n_emit  = r_emit + 1'b1;
                            n_phase = r_phase + PHASE_W'(step_eff);
                        end
                    end else begin
                        if (r_interp) begin
                            n_reached = !emit_lt;
                        end
                        n_state = S_FLUSH;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_skip  = (quot > PHASE_W'(left)) ? left : quot[lir_pkg::OFR_W-1:0];
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = PROD_W'(r_skip) * PROD_W'(step_eff);
                n_state = S_ADD;
            end
            S_ADD: begin
                n_phase = r_phase + PHASE_W'(r_prod);
                n_emit  = r_emit + r_skip;
                n_state = S_INTERP;
            end
            S_FLUSH: begin
                if (slot_free) begin
                    if (r_fin && emit_lt) begin
                        n_reached = 1'b1;
                    end
                    if (r_fin && emit_lt && !at_max) begin
                        issue  = 1'b1;
                        n_n    = r_n + 1'b1;
                        n_emit = r_emit + 1'b1;
                    end else begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                if (slot_free && (!msts.hold_valid || msts.out_free)) begin
                    n_state = S_IDLE;
                    if (r_fin) begin
                        n_have  = 1'b0;
                        n_frame = '0;
                        n_phase = '0;
                        n_emit  = '0;
                    end else begin
                        n_prev  = r_cur;
                        n_have  = 1'b1;
                        n_frame = (r_frame != '1) ? r_frame + 1'b1 : r_frame;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_step    <= lir_pkg::STEP_RST;
            r_chan    <= lir_pkg::CHAN_RST;
            r_ofr     <= lir_pkg::OFR_RST;
            r_have    <= 1'b0;
            r_frame   <= '0;
            r_phase   <= '0;
            r_emit    <= '0;
            r_n       <= '0;
            r_interp  <= 1'b0;
            r_reached <= 1'b0;
            r_fin     <= 1'b0;
            r_v1      <= 1'b0;
            r_rv      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_have    <= n_have;
            r_frame   <= n_frame;
            r_phase   <= n_phase;
            r_emit    <= n_emit;
            r_n       <= n_n;
            r_interp  <= n_interp;
            r_reached <= n_reached;
            r_fin     <= n_fin;
            r_v1      <= issue;
            r_rv      <= n_rv;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    lir_pkg::CFG_STEP: r_step <= i_cfg_data[lir_pkg::STEP_W-1:0];
                    lir_pkg::CFG_CHAN: r_chan <= i_cfg_data[lir_pkg::CHAN_W-1:0];
                    lir_pkg::CFG_OFR:  r_ofr  <= i_cfg_data[lir_pkg::OFR_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev <= n_prev;
        r_cur  <= n_cur;
        r_skip <= n_skip;
        r_prod <= n_prod;
    end

    for (genvar g = 0; g < lir_pkg::LANES; g++) begin : g_lane
        lir_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk  (i_clk),
            .i_ctl  (lane_ctl),
            .i_prev (lane_prev[g]),
            .i_cur  (r_cur[g]),
            .i_frac (lane_frac),
            .o_res  (lane_res[g])
        );
    end

    lir_div #(
        .DW (PHASE_W),
        .VW (lir_pkg::STEP_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (step_eff),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    lir_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (mctl),
        .i_res      (lane_res),
        .o_sts      (msts),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

// ===== dv/tb_linear_interp_resampler.sv =====
// tb_linear_interp_resampler: self-checking bench for the linear interpolation resampler.
// Directed rows, then random sounds under changing settings; checked by a built-in predictor or by known rows.
// Depends on lir_pkg and the linear_interp_resampler top level.
module tb_linear_interp_resampler;

    localparam int          FRAC       = lir_pkg::FRAC_BITS_DEF;
    localparam longint      ONE        = longint'(1) << FRAC;
    localparam int          SETTLE     = 200;
    localparam int unsigned LIMIT      = 2_000_000;
    localparam int          HOLD_OFF   = 400;
    localparam int          RAND_ITEMS = 400;
    localparam int          CALM_TAIL  = 80;
    localparam logic [31:0] MAXP       = 32'h7fff_ffff;
    localparam logic [31:0] MINN       = 32'h8000_0000;

    typedef struct packed {
        lir_pkg::t_frame data;
        logic            run_end;
        logic            sound_end;
    } t_interp_out;

    typedef enum {BY_MODEL, NO_RESULT, ONE_RESULT} t_row_check;

    typedef struct {
        bit                             is_cfg;
        lir_pkg::t_cfg_idx              idx;
        logic [lir_pkg::CFG_DATA_W-1:0] val;
        lir_pkg::t_frame                smp;
        logic                           fin;
        t_row_check                     chk;
        t_interp_out                    known;
    } t_stim_row;

    logic                           clk;
    logic                           rst_n     = 1'b0;
    logic                           cfg_we    = 1'b0;
    lir_pkg::t_cfg_idx              cfg_index = lir_pkg::CFG_STEP;
    logic [lir_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    lir_pkg::t_frame                s_tdata   = '0;
    logic                           s_tlast   = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [lir_pkg::TDATA_W-1:0]    m_tdata;
    logic                           m_tlast;
    logic                           m_tuser;

    bit                    idle_on   = 1'b1;
    bit                    hold_req  = 1'b0;
    int                    mismatches = 0;

    // predictor state
    logic [lir_pkg::STEP_W-1:0] step_reg;
    logic [lir_pkg::CHAN_W-1:0] chan_reg;
    logic [lir_pkg::OFR_W-1:0]  frames_reg;
    lir_pkg::t_frame            held_frame;
    bit                         held_valid;
    int unsigned                frame_idx;
    longint unsigned            out_phase;
    int unsigned                out_count;
    t_interp_out                results_due[$];

    linear_interp_resampler #(.FRAC_BITS(FRAC)) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tlast   (s_tlast),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tlast   (m_tlast),
        .o_m_tuser   (m_tuser)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic lir_pkg::t_frame frame4(input logic [31:0] a, b, c, d);
        return {d, c, b, a};
    endfunction

    function automatic t_stim_row cfg_row(lir_pkg::t_cfg_idx idx,
                                          logic [lir_pkg::CFG_DATA_W-1:0] val);
        t_stim_row r;
        r = '{is_cfg: 1'b1, idx: idx, val: val, smp: '0, fin: 1'b0, chk: BY_MODEL,
              known: '0};
        return r;
    endfunction

    function automatic t_stim_row item_row(lir_pkg::t_frame smp, logic fin,
                                           t_row_check chk = BY_MODEL,
                                           t_interp_out known = '0);
        t_stim_row r;
        r = '{is_cfg: 1'b0, idx: lir_pkg::CFG_STEP, val: '0, smp: smp, fin: fin, chk: chk,
              known: known};
        return r;
    endfunction

    function automatic void forget_sound();
        held_frame = '0;
        held_valid = 1'b0;
        frame_idx  = 0;
        out_phase  = 0;
        out_count  = 0;
    endfunction

    function automatic void apply_reg(lir_pkg::t_cfg_idx idx,
                                      logic [lir_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            lir_pkg::CFG_STEP: step_reg   = val[lir_pkg::STEP_W-1:0];
            lir_pkg::CFG_CHAN: chan_reg   = val[lir_pkg::CHAN_W-1:0];
            lir_pkg::CFG_OFR:  frames_reg = val[lir_pkg::OFR_W-1:0];
            default: ;
        endcase
    endfunction

    // Interpolated outputs caused by one input frame; queued when keep is set.
    function automatic void predict_frame(lir_pkg::t_frame smp, logic fin, bit keep);
        t_interp_out     batch[lir_pkg::MAX_OUT];
        lir_pkg::t_frame cur;
        int unsigned     act;
        longint unsigned stp, hi, skip, frac;
        longint          acc;
        bit              reached;
        int              n;
        reached = 1'b0;
        n       = 0;
        act     = (chan_reg == 0) ? 1 : (chan_reg > lir_pkg::LANES) ? lir_pkg::LANES : chan_reg;
        stp     = (step_reg == 0) ? 1 : step_reg;
        cur     = '0;
        for (int i = 0; i < lir_pkg::LANES; i++)
            if (i < act) cur[i] = smp[i];
        if (held_valid && out_count < frames_reg) begin
            hi = frame_idx;
            hi = hi << FRAC;
            while (out_count < frames_reg && out_phase < hi) begin
                if (n >= lir_pkg::MAX_OUT) begin
                    // over the per-item cap: outputs dropped but still counted
                    skip = (hi - out_phase + stp - 1) / stp;
                    if (skip > frames_reg - out_count) skip = frames_reg - out_count;
                    out_count += 32'(skip);
                    out_phase += skip * stp;
                    break;
                end
                frac     = out_phase & longint'(ONE - 1);
                batch[n] = '0;
                for (int i = 0; i < lir_pkg::LANES; i++) begin
                    acc = longint'(signed'(held_frame[i])) * longint'(ONE - frac)
                        + longint'(signed'(cur[i])) * longint'(frac);
                    batch[n].data[i] = 32'(acc / ONE);
                end
                n++;
                out_count++;
                out_phase += stp;
            end
            if (out_count >= frames_reg) reached = 1'b1;
        end
        if (fin) begin
            if (out_count < frames_reg) begin
                while (out_count < frames_reg && n < lir_pkg::MAX_OUT) begin
                    batch[n] = '{data: cur, run_end: 1'b0, sound_end: 1'b0};
                    n++;
                    out_count++;
                end
                reached = 1'b1;
            end
            forget_sound();
        end else begin
            held_frame = cur;
            held_valid = 1'b1;
            if (frame_idx != '1) frame_idx++;
        end
        if (n > 0) begin
            batch[n-1].run_end   = 1'b1;
            batch[n-1].sound_end = reached;
        end
        if (keep)
            for (int i = 0; i < n; i++) results_due.push_back(batch[i]);
    endfunction

    task automatic send_frame(lir_pkg::t_frame smp, logic fin, bit keep);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= fin;
        do @(posedge clk); while (!s_tready);
        predict_frame(smp, fin, keep);
    endtask

    // Block idle: all results in, then enough cycles for any trailing skip.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(lir_pkg::t_cfg_idx idx, logic [lir_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        apply_reg(idx, val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge clk);
            if (stall > 0)
                stall--;
            else if (hold_req) begin
                hold_req = 1'b0;
                stall    = HOLD_OFF;
            end else if (idle_on && $urandom_range(0, 7) == 0)
                stall = $urandom_range(1, 15);
            m_tready <= (stall == 0);
        end
    end

    always @(posedge clk) begin : watch_results
        t_interp_out want;
        bit          bad;
        if (rst_n && m_tvalid && m_tready) begin
            if (results_due.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected item: data=%h last=%b user=%b",
                             m_tdata, m_tlast, m_tuser);
                mismatches++;
            end else begin
                want = results_due.pop_front();
                bad  = 1'b0;
                for (int i = 0; i < lir_pkg::LANES; i++)
                    if (m_tdata[i*lir_pkg::SAMPLE_W +: lir_pkg::SAMPLE_W] !== want.data[i])
                        bad = 1'b1;
                if (m_tlast !== want.run_end || m_tuser !== want.sound_end) bad = 1'b1;
                if (bad) begin
                    if (mismatches < 10)
                        $display({"mismatch: exp data=%h last=%b user=%b,",
                                  " got data=%h last=%b user=%b"},
                                 want.data, want.run_end, want.sound_end,
                                 m_tdata, m_tlast, m_tuser);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL linear_interp_resampler");
        $finish;
    end

    initial begin
        t_stim_row                      rows[$];
        lir_pkg::t_frame                smp;
        logic [lir_pkg::CFG_DATA_W-1:0] val;
        int                             rand_items, phase, sounds, len;
        bit                             open_end;
        step_reg   = lir_pkg::STEP_RST;
        chan_reg   = lir_pkg::CHAN_RST;
        frames_reg = lir_pkg::OFR_RST;
        forget_sound();
        rows = '{
            // defaults: two lanes, one output, unit step
            item_row(frame4(1000, -2000, 3000, -4000), 1'b1, ONE_RESULT,
                     t_interp_out'{frame4(1000, -2000, 0, 0), 1'b1, 1'b1}),
            item_row(frame4(5, 6, 7, 8), 1'b0, NO_RESULT),
            item_row(frame4(-7, 9, 11, 13), 1'b0, ONE_RESULT,
                     t_interp_out'{frame4(5, 6, 0, 0), 1'b1, 1'b1}),
            item_row(frame4(1, 2, 3, 4), 1'b1, NO_RESULT),
            cfg_row(lir_pkg::CFG_CHAN, 4),
            cfg_row(lir_pkg::CFG_OFR, 0),
            item_row(frame4(MAXP, MINN, -1, 0), 1'b0, NO_RESULT),
            item_row(frame4(MINN, MAXP, 0, -1), 1'b1, NO_RESULT),
            cfg_row(lir_pkg::CFG_OFR, 5),
            cfg_row(lir_pkg::CFG_STEP, 0),
            item_row(frame4(MAXP, MINN, -1, 0), 1'b0),
            item_row(frame4(MINN, MAXP, 0, -1), 1'b1),
            cfg_row(lir_pkg::CFG_CHAN, 0),
            cfg_row(lir_pkg::CFG_STEP, 'hff_ffff),
            cfg_row(lir_pkg::CFG_OFR, 'h7fff_ffff),
            item_row(frame4(MINN, 1, 2, 3), 1'b0),
            item_row(frame4(MAXP, 4, 5, 6), 1'b0),
            item_row(frame4(-1, 7, 8, 9), 1'b1),
            cfg_row(lir_pkg::CFG_CHAN, 7),
            cfg_row(lir_pkg::CFG_STEP, 1),
            cfg_row(lir_pkg::CFG_OFR, 100),
            item_row(frame4(MINN, MAXP, MINN, MAXP), 1'b0),
            item_row(frame4(MAXP, MINN, MAXP, MINN), 1'b0),
            item_row(frame4(3, 3, 3, 3), 1'b1),
            cfg_row(lir_pkg::CFG_CHAN, 3),
            cfg_row(lir_pkg::CFG_STEP, 'h1_8000),
            cfg_row(lir_pkg::CFG_OFR, 6),
            item_row(frame4(100, -100, 1000, 5), 1'b0),
            item_row(frame4(-300, 300, -3000, 5), 1'b0),
            cfg_row(lir_pkg::CFG_STEP, 'h8000),
            item_row(frame4(700, 0, 70000, 5), 1'b0),
            item_row(frame4(-900, 9, -9, 5), 1'b0),
            item_row(frame4(11, 22, 33, 44), 1'b1)
        };
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[r]) begin
            if (rows[r].is_cfg) begin
                settle();
                write_reg(rows[r].idx, rows[r].val);
            end else begin
                send_frame(rows[r].smp, rows[r].fin, rows[r].chk == BY_MODEL);
                if (rows[r].chk == ONE_RESULT) results_due.push_back(rows[r].known);
            end
        end

        rand_items = 0;
        phase      = 0;
        while (rand_items < RAND_ITEMS) begin
            settle();
            if (phase == 0) begin
                // steady upsampling so the long receiver hold-off backs the block up
                write_reg(lir_pkg::CFG_STEP, 'h4000);
                write_reg(lir_pkg::CFG_CHAN, 4);
                write_reg(lir_pkg::CFG_OFR, 'h7fff_ffff);
                hold_req = 1'b1;
            end else begin
                case ($urandom_range(0, 9))
                    0:       val = lir_pkg::CFG_DATA_W'($urandom_range(0, 'h800));
                    1:       val = lir_pkg::CFG_DATA_W'($urandom_range('h10_0000, 'hff_ffff));
                    2:       val = 'h1_0000;
                    default: val = lir_pkg::CFG_DATA_W'($urandom_range('h2800, 'h4_0000));
                endcase
                write_reg(lir_pkg::CFG_STEP, val);
                write_reg(lir_pkg::CFG_CHAN, lir_pkg::CFG_DATA_W'($urandom_range(0, 7)));
                case ($urandom_range(0, 7))
                    0:       val = '0;
                    1:       val = '1;
                    2:       val = lir_pkg::CFG_DATA_W'($urandom());
                    default: val = lir_pkg::CFG_DATA_W'($urandom_range(1, 60));
                endcase
                write_reg(lir_pkg::CFG_OFR, val);
            end
            sounds   = $urandom_range(2, 6);
            open_end = ($urandom_range(0, 4) == 0);
            for (int s = 0; s < sounds; s++) begin
                len = $urandom_range(1, 10);
                for (int f = 0; f < len; f++) begin
                    for (int i = 0; i < lir_pkg::LANES; i++)
                        case ($urandom_range(0, 15))
                            0:       smp[i] = MAXP;
                            1:       smp[i] = MINN;
                            2:       smp[i] = '0;
                            3:       smp[i] = '1;
                            default: smp[i] = $urandom();
                        endcase
                    // an open last sound carries over into the next setting
                    send_frame(smp, f == len - 1 && !(open_end && s == sounds - 1), 1'b1);
                    rand_items++;
                    idle_on = (rand_items < RAND_ITEMS - CALM_TAIL);
                end
            end
            phase++;
        end

        s_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("PASS linear_interp_resampler");
        else
            $display("FAIL linear_interp_resampler");
        $finish;
    end

endmodule
